[hw/rtl/ufv_pkg.sv]
// Shared types and codes for the UART frame validator.
package ufv_pkg;

	localparam int unsigned LenW = 17;

	localparam logic [2:0] ST_VALID    = 3'd0;
	localparam logic [2:0] ST_SHORT    = 3'd1;
	localparam logic [2:0] ST_LONG     = 3'd2;
	localparam logic [2:0] ST_HEADER   = 3'd3;
	localparam logic [2:0] ST_CHECKSUM = 3'd4;

	localparam logic [1:0] REG_HEADER_MAGIC  = 2'd0;
	localparam logic [1:0] REG_MIN_FRAME_LEN = 2'd1;
	localparam logic [1:0] REG_MAX_FRAME_LEN = 2'd2;

	localparam logic [LenW-1:0] FRAME_OVERHEAD = 17'd8;
	localparam logic [LenW-1:0] MIN_LEN_RESET  = 17'd8;
	localparam logic [LenW-1:0] MAX_LEN_RESET  = 17'd65543;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  command;
		logic [15:0] param_length;
		logic [7:0]  computed_xor;
		logic [7:0]  received_xor;
	} out_item_t;

	typedef struct packed {
		logic [31:0]     header_magic;
		logic [LenW-1:0] min_frame_len;
		logic [LenW-1:0] max_frame_len;
	} cfg_t;

endpackage

[hw/rtl/ufv_cfg_regs.sv]
// Configuration register file of the UART frame validator.
module ufv_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	output ufv_pkg::cfg_t    cfg
);
	import ufv_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_magic  <= '0;
			cfg_q.min_frame_len <= MIN_LEN_RESET;
			cfg_q.max_frame_len <= MAX_LEN_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HEADER_MAGIC:  cfg_q.header_magic  <= cfg_data;
				REG_MIN_FRAME_LEN: cfg_q.min_frame_len <= cfg_data[LenW-1:0];
				REG_MAX_FRAME_LEN: cfg_q.max_frame_len <= cfg_data[LenW-1:0];
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/ufv_in_stage.sv]
// Input register stage that holds one received byte for the parser.
module ufv_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ufv_pkg::in_item_t in_item,
	input  logic              advance,
	output logic              valid_s1,
	output ufv_pkg::in_item_t item_s1
);
	import ufv_pkg::*;

	logic     valid_s1_r;
	in_item_t item_s1_r;

	assign in_stall = valid_s1_r && !advance;
	assign valid_s1 = valid_s1_r;
	assign item_s1  = item_s1_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_r <= 1'b0;
		end else if (!in_stall) begin
			valid_s1_r <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1_r <= in_item;
		end
	end

endmodule

[hw/rtl/ufv_parser.sv]
// Frame parser state and the registered status output.
module ufv_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  ufv_pkg::cfg_t      cfg,
	input  logic               valid_s1,
	input  ufv_pkg::in_item_t  item_s1,
	output logic               advance,
	output logic               out_valid,
	input  logic               out_stall,
	output ufv_pkg::out_item_t out_item
);
	import ufv_pkg::*;

	localparam logic [2:0] PH_HUNT   = 3'd0;
	localparam logic [2:0] PH_HEADER = 3'd1;
	localparam logic [2:0] PH_CMD    = 3'd2;
	localparam logic [2:0] PH_LENHI  = 3'd3;
	localparam logic [2:0] PH_LENLO  = 3'd4;
	localparam logic [2:0] PH_PARAM  = 3'd5;
	localparam logic [2:0] PH_CSUM   = 3'd6;

	logic [2:0]  phase_q, phase_d;
	logic [15:0] pos_q, pos_d;
	logic [31:0] header_q, header_d;
	logic [7:0]  xor_q, xor_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [15:0] len_q, len_d;

	logic            emit;
	logic [2:0]      status;
	logic [7:0]      rx_xor;
	logic [7:0]      b;
	logic [15:0]     pos_inc;
	logic [LenW-1:0] total;
	logic            take;
	logic            out_valid_q;
	out_item_t       out_item_q;

	assign advance  = !out_valid_q || !out_stall;
	assign take     = valid_s1 && advance;
	assign b        = item_s1.data_byte;
	assign pos_inc  = pos_q + 16'd1;
	assign total    = FRAME_OVERHEAD + {1'b0, len_q[15:8], b};

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		header_d = header_q;
		xor_d    = xor_q;
		cmd_d    = cmd_q;
		len_d    = len_q;
		emit     = 1'b0;
		status   = ST_VALID;
		rx_xor   = 8'd0;
		if (item_s1.first_byte) begin
			header_d = {24'd0, b};
			xor_d    = b;
			pos_d    = 16'd1;
			cmd_d    = 8'd0;
			len_d    = 16'd0;
			phase_d  = PH_HEADER;
		end else begin
			unique case (phase_q)
				PH_HEADER: begin
					header_d = {header_q[23:0], b};
					xor_d    = xor_q ^ b;
					pos_d    = pos_inc;
					if (pos_inc >= 16'd4) begin
						phase_d = PH_CMD;
					end
				end
				PH_CMD: begin
					cmd_d   = b;
					xor_d   = xor_q ^ b;
					phase_d = PH_LENHI;
				end
				PH_LENHI: begin
					len_d   = {b, 8'd0};
					xor_d   = xor_q ^ b;
					phase_d = PH_LENLO;
				end
				PH_LENLO: begin
					len_d = {len_q[15:8], b};
					xor_d = xor_q ^ b;
					if (total < cfg.min_frame_len) begin
						emit   = 1'b1;
						status = ST_SHORT;
					end else if (total > cfg.max_frame_len) begin
						emit   = 1'b1;
						status = ST_LONG;
					end else if (header_q != cfg.header_magic) begin
						emit   = 1'b1;
						status = ST_HEADER;
					end
					if (emit) begin
						phase_d = PH_HUNT;
					end else begin
						pos_d   = 16'd0;
						phase_d = ({len_q[15:8], b} == 16'd0) ? PH_CSUM : PH_PARAM;
					end
				end
				PH_PARAM: begin
					xor_d = xor_q ^ b;
					pos_d = pos_inc;
					if (pos_inc >= len_q) begin
						phase_d = PH_CSUM;
					end
				end
				PH_CSUM: begin
					emit    = 1'b1;
					status  = (xor_q == b) ? ST_VALID : ST_CHECKSUM;
					rx_xor  = b;
					phase_d = PH_HUNT;
				end
				default: phase_d = PH_HUNT;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			pos_q       <= '0;
			header_q    <= '0;
			xor_q       <= '0;
			cmd_q       <= '0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= take && emit;
			if (take) begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				header_q <= header_d;
				xor_q    <= xor_d;
				cmd_q    <= cmd_d;
				len_q    <= len_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_item_q.status       <= status;
			out_item_q.command      <= cmd_d;
			out_item_q.param_length <= len_d;
			out_item_q.computed_xor <= xor_d;
			out_item_q.received_xor <= rx_xor;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

[hw/rtl/uart_frame_validator.sv]
// Top level of the UART frame validator.
// The block takes one received byte per clock cycle while in_stall is low and gives at most
// one status per byte: an accepted byte is held in the input register, and the parser
// writes its status into the output register. A frame reports either an early status on its
// second length byte or a final checksum status on its last byte. The output register and the
// input register together let a new byte enter while a status waits to be taken.
// Configuration writes are always ready and take effect at the next cycle.
module uart_frame_validator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ufv_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output ufv_pkg::out_item_t  out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	import ufv_pkg::*;

	cfg_t     cfg;
	logic     advance;
	logic     valid_s1;
	in_item_t item_s1;

	ufv_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ufv_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	ufv_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.advance   (advance),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	a_stall_needs_held_byte: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("Input stalled without a held byte and a blocked output.");

	a_valid_status_matches_xor: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.status == ST_VALID) |->
		(out_item.computed_xor == out_item.received_xor))
		else $error("Valid status given with mismatching checksums.");

	a_early_status_no_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_item.status == ST_SHORT || out_item.status == ST_LONG ||
		out_item.status == ST_HEADER)) |-> (out_item.received_xor == 8'd0))
		else $error("Early status carries a checksum byte.");

	a_status_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.status <= ST_CHECKSUM))
		else $error("Status code out of range.");

endmodule
